/* rtl/core/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// Configuration text tokeniser package
// Shared types, character codes and sizing constants for the tokeniser.
// ----------------------------------------------------------------------------
package ctt_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int FIELD_BITS  = 16;

   localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
   localparam logic [OFFSET_BITS-1:0] POS_ZERO = '0;
   localparam logic [OFFSET_BITS-1:0] POS_ONE  = OFFSET_BITS'(1);
   localparam logic [FIELD_BITS-1:0]  LINE_MAX = '1;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_BITS:0] QUEUE_FULL_COUNT = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_LCURLY     = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY     = 8'h7D;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_IDENT   = 3'd2,
      MODE_NUMBER  = 3'd3,
      MODE_STRING  = 3'd4
   } scan_mode_type;

   typedef enum logic [3:0] {
      KIND_END        = 4'd0,
      KIND_UNEXPECTED = 4'd1,
      KIND_IDENT      = 4'd2,
      KIND_NUMBER     = 4'd3,
      KIND_LCURLY     = 4'd4,
      KIND_RCURLY     = 4'd5,
      KIND_EQUAL      = 4'd6,
      KIND_STRING     = 4'd7,
      KIND_COMMA      = 4'd8
   } token_kind_type;

   typedef struct packed {
      token_kind_type        kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] line;
   } token_type;

   // All tokens caused by one text byte: one or two of them.
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } pair_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

/* rtl/core/config_text_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// Configuration text tokeniser, top level
// Path: a byte's tokens go into a queue entry, then into the output register.
// Throughput: one text byte per cycle while the queue is not full; a byte
// giving two tokens needs a beat per token, which the four-entry queue absorbs.
// Reset: synchronous; scan state, position and queue clear, first line is 1.
// ----------------------------------------------------------------------------
module config_text_tokenizer_unit
   import ctt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_token_kind,
   output logic [FIELD_BITS-1:0] rsp_token_start,
   output logic [FIELD_BITS-1:0] rsp_token_length,
   output logic [FIELD_BITS-1:0] rsp_line_number,
   output logic                  rsp_run_last
);

   // The front end scans one byte per beat and writes every token that the
   // byte causes into a single queue entry. Bytes that cause no token, such as
   // white space or comment text, leave the queue untouched.
   logic             push;
   pair_type         push_entry;
   logic             pop;
   queue_status_type q_status;
   pair_type         q_head;

   // The input side is held off only when the queue has no free entry; the
   // full flag is decoded from the count register alone, so stall is clean.
   assign req_stall = q_status.full;

   ctt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_entry       (push_entry)
   );

   ctt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (q_status),
      .head       (q_head)
   );

   // The back end walks through the tokens of the head entry, one per output
   // beat, and releases the entry with its last token.
   ctt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (q_status),
      .head             (q_head),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_run_last     (rsp_run_last)
   );

   // The front end must never write into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("token entry written into a full queue");

   // The end token is always the last token of its byte and carries line zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == KIND_END) |-> (rsp_run_last && rsp_line_number == '0))
      else $error("end token is not last or has a line number");

   // The second token of a byte follows on the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_run_last) |=> rsp_valid)
      else $error("second token of a byte did not follow at once");

endmodule

/* rtl/core/ctt_front.sv */
// ----------------------------------------------------------------------------
// Tokeniser front end
// Holds the scan state, classifies each text byte and pushes the tokens it
// causes into the queue as one entry.
// ----------------------------------------------------------------------------
module ctt_front
   import ctt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output logic       push,
   output pair_type   push_entry
);

   scan_mode_type          mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic [FIELD_BITS-1:0]  line_ff, line_in;
   logic                   first_line_ff;
   logic                   accept;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[FIELD_BITS-1:0];
   endfunction

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= 1'b1;
         mode_ff       <= MODE_BETWEEN;
         pos_ff        <= POS_ZERO;
         begin_ff      <= POS_ZERO;
         line_ff       <= FIELD_BITS'(1);
      end else begin
         if (csr_write_enable) begin
            first_line_ff <= csr_write_data;
         end
         if (accept) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            begin_ff <= begin_in;
            line_ff  <= line_in;
         end
      end
   end

   always_comb begin
      logic [7:0]             c;
      logic [FIELD_BITS-1:0]  span;
      token_type              bt_tok;
      logic                   bt_emit;
      scan_mode_type          bt_mode;
      logic                   bt_set_begin;
      logic [OFFSET_BITS-1:0] bt_begin;
      logic                   bt_bump;
      logic                   bt_restart;
      token_type              pre_tok;
      logic                   pre_emit;
      logic                   use_bt;
      logic                   bump;
      logic                   restart;
      logic                   bt_valid;

      c    = req_text_byte;
      span = (pos_ff >= begin_ff) ? to_field(pos_ff - begin_ff) : '0;

      // Scan of a byte that arrives between tokens.
      bt_emit       = 1'b0;
      bt_tok.kind   = KIND_UNEXPECTED;
      bt_tok.start  = to_field(pos_ff);
      bt_tok.length = FIELD_BITS'(1);
      bt_tok.line   = line_ff;
      bt_mode       = MODE_BETWEEN;
      bt_set_begin  = 1'b0;
      bt_begin      = pos_ff;
      bt_bump       = 1'b0;
      bt_restart    = 1'b0;
      priority if (c == CHAR_NUL) begin
         bt_emit     = 1'b1;
         bt_tok.kind = KIND_END;
         bt_tok.line = '0;
         bt_restart  = 1'b1;
      end else if (c == CHAR_HASH) begin
         bt_mode = MODE_COMMENT;
      end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR) begin
         bt_mode = MODE_BETWEEN;
      end else if (c == CHAR_NEWLINE) begin
         bt_bump = 1'b1;
      end else if (is_letter(c)) begin
         bt_mode      = MODE_IDENT;
         bt_set_begin = 1'b1;
      end else if (is_digit(c)) begin
         bt_mode      = MODE_NUMBER;
         bt_set_begin = 1'b1;
      end else if (c == CHAR_QUOTE) begin
         bt_mode      = MODE_STRING;
         bt_set_begin = 1'b1;
         bt_begin     = (pos_ff < POS_MAX) ? pos_ff + POS_ONE : POS_MAX;
      end else begin
         bt_emit = 1'b1;
         unique case (c)
            CHAR_LCURLY: bt_tok.kind = KIND_LCURLY;
            CHAR_RCURLY: bt_tok.kind = KIND_RCURLY;
            CHAR_EQUAL:  bt_tok.kind = KIND_EQUAL;
            CHAR_COMMA:  bt_tok.kind = KIND_COMMA;
            default:     bt_tok.kind = KIND_UNEXPECTED;
         endcase
      end

      // Token closed by this byte, if any.
      pre_emit       = 1'b0;
      pre_tok.kind   = KIND_IDENT;
      pre_tok.start  = to_field(begin_ff);
      pre_tok.length = span;
      pre_tok.line   = line_ff;
      use_bt         = 1'b0;
      bump           = 1'b0;
      mode_in        = mode_ff;
      unique case (mode_ff)
         MODE_COMMENT: begin
            if (c == CHAR_NUL) begin
               use_bt = 1'b1;
            end else if (c == CHAR_NEWLINE) begin
               bump    = 1'b1;
               mode_in = MODE_BETWEEN;
            end
         end
         MODE_IDENT: begin
            if (!(is_letter(c) || is_digit(c) || c == CHAR_UNDERSCORE)) begin
               pre_emit = 1'b1;
               use_bt   = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (!is_digit(c)) begin
               pre_emit     = 1'b1;
               pre_tok.kind = KIND_NUMBER;
               use_bt       = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == CHAR_QUOTE) begin
               pre_emit     = 1'b1;
               pre_tok.kind = KIND_STRING;
               mode_in      = MODE_BETWEEN;
            end else if (c == CHAR_NUL) begin
               pre_emit     = 1'b1;
               pre_tok.kind = KIND_UNEXPECTED;
               use_bt       = 1'b1;
            end
         end
         default: begin
            use_bt = 1'b1;
         end
      endcase

      begin_in = begin_ff;
      if (use_bt) begin
         mode_in = bt_mode;
         bump    = bt_bump;
         if (bt_set_begin) begin
            begin_in = bt_begin;
         end
      end

      line_in  = (bump && line_ff != LINE_MAX) ? line_ff + FIELD_BITS'(1) : line_ff;
      pos_in   = (pos_ff < POS_MAX) ? pos_ff + POS_ONE : pos_ff;
      restart  = use_bt && bt_restart;
      if (restart) begin
         mode_in  = MODE_BETWEEN;
         pos_in   = POS_ZERO;
         begin_in = POS_ZERO;
         line_in  = FIELD_BITS'(first_line_ff);
      end

      bt_valid        = use_bt && bt_emit;
      push            = accept && (pre_emit || bt_valid);
      push_entry.two  = pre_emit && bt_valid;
      push_entry.tok0 = pre_emit ? pre_tok : bt_tok;
      push_entry.tok1 = bt_tok;
   end

endmodule

/* rtl/core/ctt_queue.sv */
// ----------------------------------------------------------------------------
// Tokeniser queue
// Short first-in first-out store of token entries between front and back end.
// ----------------------------------------------------------------------------
module ctt_queue
   import ctt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pair_type         push_entry,
   input  logic             pop,
   output queue_status_type status,
   output pair_type         head
);

   pair_type                  entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_PTR_BITS + 1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_PTR_BITS + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_FULL_COUNT);
   assign head         = entries_ff[rd_ptr_ff];

endmodule

/* rtl/core/ctt_back.sv */
// ----------------------------------------------------------------------------
// Tokeniser back end
// Takes entries from the queue and hands their tokens out one beat at a time
// through the output register.
// ----------------------------------------------------------------------------
module ctt_back
   import ctt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      status,
   input  pair_type              head,
   output logic                  pop,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_token_kind,
   output logic [FIELD_BITS-1:0] rsp_token_start,
   output logic [FIELD_BITS-1:0] rsp_token_length,
   output logic [FIELD_BITS-1:0] rsp_line_number,
   output logic                  rsp_run_last
);

   logic      valid_ff;
   logic      second_ff;
   token_type tok_ff;
   logic      last_ff;
   logic      load;
   logic      take;
   logic      is_last;

   // Output register may be refilled when empty or being taken this cycle.
   assign load    = !valid_ff || !rsp_stall;
   assign take    = load && !status.empty;
   assign is_last = !head.two || second_ff;
   assign pop     = take && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= !status.empty;
         if (take) begin
            second_ff <= !is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff  <= second_ff ? head.tok1 : head.tok0;
         last_ff <= is_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_start  = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_line_number  = tok_ff.line;
   assign rsp_run_last     = last_ff;

endmodule

/* bench/config_text_tokenizer_unit_tb.sv */
// ----------------------------------------------------------------------------
// Configuration text tokeniser regression bench
// Streams a directed text, short configuration texts and random noise through
// the tokeniser, mostly under random idling on both sides, then a tail with no
// idling at all. Every token beat is checked field by field against a scanner
// kept inside this bench.
// ----------------------------------------------------------------------------
module config_text_tokenizer_unit_tb;
   import ctt_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BYTES  = 1500;
   localparam int PHASE_BYTES   = 300;
   localparam int TAIL_BYTES    = 250;
   localparam int SETTLE_CYCLES = 6;

   // One expected token beat on the result side.
   typedef struct {
      token_kind_type        kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] line;
      logic                  run_last;
   } token_beat_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_text_byte    = 8'h00;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [3:0]            rsp_token_kind;
   logic [FIELD_BITS-1:0] rsp_token_start;
   logic [FIELD_BITS-1:0] rsp_token_length;
   logic [FIELD_BITS-1:0] rsp_line_number;
   logic                  rsp_run_last;

   // Bytes waiting to be offered, and tokens the scanner says must come back.
   logic [7:0]     text_backlog[$];
   token_beat_type expected_tokens[$];

   int send_gap          = 0;
   int stall_left        = 0;
   int cycle_count       = 0;
   int mismatches        = 0;
   int bytes_queued      = 0;
   int bytes_accepted    = 0;
   bit idle_enable       = 1'b0;
   bit long_hold_request = 1'b0;

   // Scanner state, mirroring what the block should hold.
   scan_mode_type          lex_mode       = MODE_BETWEEN;
   logic [OFFSET_BITS-1:0] lex_pos        = '0;
   logic [OFFSET_BITS-1:0] lex_begin      = '0;
   logic [FIELD_BITS-1:0]  lex_line       = FIELD_BITS'(1);
   logic                   first_line_cfg = 1'b1;
   bit                     lex_restart    = 1'b0;

   config_text_tokenizer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_run_last     (rsp_run_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Scanner
   // ------------------------------------------------------------------------

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
   endfunction

   function automatic void expect_token(input token_kind_type kind,
                                        input logic [OFFSET_BITS-1:0] start,
                                        input logic [OFFSET_BITS-1:0] length,
                                        input logic [FIELD_BITS-1:0] line);
      token_beat_type tok;
      tok.kind     = kind;
      tok.start    = FIELD_BITS'(start);
      tok.length   = FIELD_BITS'(length);
      tok.line     = line;
      tok.run_last = 1'b0;
      expected_tokens.push_back(tok);
   endfunction

   // The line count sticks at its top value rather than wrapping.
   function automatic void count_line();
      if (lex_line != LINE_MAX)
         lex_line++;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] token_span();
      return (lex_pos >= lex_begin) ? lex_pos - lex_begin : POS_ZERO;
   endfunction

   // Treats a byte as the first of a new token. This is also where a byte
   // that closed an identifier or a number gets its second look.
   function automatic void scan_fresh(input logic [7:0] c);
      lex_mode = MODE_BETWEEN;
      if (c == CHAR_NUL) begin
         // End of text: the end token carries no line, then everything
         // starts over with the line count reloaded from the register.
         expect_token(KIND_END, lex_pos, POS_ONE, '0);
         lex_pos     = '0;
         lex_begin   = '0;
         lex_line    = FIELD_BITS'(first_line_cfg);
         lex_restart = 1'b1;
      end else if (c == CHAR_HASH) begin
         lex_mode = MODE_COMMENT;
      end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR) begin
         lex_mode = MODE_BETWEEN;
      end else if (c == CHAR_NEWLINE) begin
         count_line();
      end else if (is_letter(c)) begin
         lex_mode  = MODE_IDENT;
         lex_begin = lex_pos;
      end else if (is_digit(c)) begin
         lex_mode  = MODE_NUMBER;
         lex_begin = lex_pos;
      end else if (c == CHAR_QUOTE) begin
         // String contents start after the quote, unless the position has
         // already stuck at its top value.
         lex_mode  = MODE_STRING;
         lex_begin = (lex_pos != POS_MAX) ? lex_pos + POS_ONE : POS_MAX;
      end else begin
         case (c)
            CHAR_LCURLY: expect_token(KIND_LCURLY, lex_pos, POS_ONE, lex_line);
            CHAR_RCURLY: expect_token(KIND_RCURLY, lex_pos, POS_ONE, lex_line);
            CHAR_EQUAL:  expect_token(KIND_EQUAL, lex_pos, POS_ONE, lex_line);
            CHAR_COMMA:  expect_token(KIND_COMMA, lex_pos, POS_ONE, lex_line);
            default:     expect_token(KIND_UNEXPECTED, lex_pos, POS_ONE, lex_line);
         endcase
      end
   endfunction

   // Works out every token one accepted text byte causes and marks the last.
   function automatic void tokenise_byte(input logic [7:0] c);
      int prior_count;
      prior_count = expected_tokens.size();
      lex_restart = 1'b0;
      case (lex_mode)
         MODE_COMMENT: begin
            if (c == CHAR_NUL) begin
               scan_fresh(c);
            end else if (c == CHAR_NEWLINE) begin
               count_line();
               lex_mode = MODE_BETWEEN;
            end
         end
         MODE_IDENT: begin
            // The identifier keeps the line count from before its closing
            // byte, even when that byte is a newline.
            if (!(is_letter(c) || is_digit(c) || c == CHAR_UNDERSCORE)) begin
               expect_token(KIND_IDENT, lex_begin, token_span(), lex_line);
               scan_fresh(c);
            end
         end
         MODE_NUMBER: begin
            if (!is_digit(c)) begin
               expect_token(KIND_NUMBER, lex_begin, token_span(), lex_line);
               scan_fresh(c);
            end
         end
         MODE_STRING: begin
            // Newlines inside a string are contents and are not counted.
            if (c == CHAR_QUOTE) begin
               expect_token(KIND_STRING, lex_begin, token_span(), lex_line);
               lex_mode = MODE_BETWEEN;
            end else if (c == CHAR_NUL) begin
               expect_token(KIND_UNEXPECTED, lex_begin, token_span(), lex_line);
               scan_fresh(c);
            end
         end
         default: scan_fresh(c);
      endcase
      if (!lex_restart && lex_pos != POS_MAX)
         lex_pos++;
      if (expected_tokens.size() > prior_count)
         expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Text generation
   // ------------------------------------------------------------------------

   function automatic void put_byte(input logic [7:0] b);
      text_backlog.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 1))
         return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
   endfunction

   function automatic void queue_blank();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) put_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   function automatic void queue_ident();
      int n;
      n = $urandom_range(0, 5);
      put_byte(pick_letter());
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       put_byte(8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9)));
            1:       put_byte(CHAR_UNDERSCORE);
            default: put_byte(pick_letter());
         endcase
      end
   endfunction

   function automatic void queue_number();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) put_byte(8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9)));
   endfunction

   // Contents are mostly printable, with the odd newline or high byte.
   function automatic void queue_string(input bit closed);
      int          n;
      logic [7:0]  b;
      n = $urandom_range(0, 6);
      put_byte(CHAR_QUOTE);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0: b = CHAR_NEWLINE;
            1: b = 8'($urandom_range(8'h80, 8'hFF));
            default: begin
               b = 8'($urandom_range(CHAR_SPACE, 8'h7E));
               if (b == CHAR_QUOTE)
                  b = CHAR_SPACE;
            end
         endcase
         put_byte(b);
      end
      if (closed)
         put_byte(CHAR_QUOTE);
   endfunction

   // Anything but a newline or the end byte may sit inside a comment.
   function automatic void queue_comment(input bit closed);
      int         n;
      logic [7:0] b;
      n = $urandom_range(0, 8);
      put_byte(CHAR_HASH);
      repeat (n) begin
         b = 8'($urandom_range(1, 255));
         put_byte(b == CHAR_NEWLINE ? CHAR_SPACE : b);
      end
      if (closed)
         put_byte(CHAR_NEWLINE);
   endfunction

   function automatic void queue_value(input bit allow_list);
      int n;
      case ($urandom_range(0, allow_list ? 3 : 2))
         0: queue_number();
         1: queue_string(1'b1);
         2: queue_ident();
         default: begin
            n = $urandom_range(0, 3);
            put_byte(CHAR_LCURLY);
            for (int i = 0; i < n; i++) begin
               if (i != 0)
                  put_byte(CHAR_COMMA);
               queue_blank();
               queue_value(1'b0);
            end
            put_byte(CHAR_RCURLY);
         end
      endcase
   endfunction

   // A well-formed "name = value" line with random spacing and content.
   function automatic void queue_entry();
      if ($urandom_range(0, 1))
         queue_blank();
      queue_ident();
      queue_blank();
      put_byte(CHAR_EQUAL);
      queue_blank();
      queue_value(1'b1);
      queue_blank();
      if ($urandom_range(0, 3) == 0)
         put_byte(CHAR_COMMA);
      if ($urandom_range(0, 3) == 0)
         put_byte(CHAR_CR);
      put_byte(CHAR_NEWLINE);
   endfunction

   // Mostly well-formed texts; some noise bytes, stray values and texts that
   // are cut off inside a string, comment or token by the end byte.
   function automatic void queue_random_text();
      int entries;
      bit cut;
      entries = $urandom_range(1, 6);
      cut     = 1'b0;
      for (int e = 0; e < entries && !cut; e++) begin
         case ($urandom_range(0, 11))
            0: queue_comment(1'b1);
            1: put_byte(8'($urandom_range(1, 255)));
            2: begin
               cut = 1'b1;
               case ($urandom_range(0, 3))
                  0: queue_string(1'b0);
                  1: queue_comment(1'b0);
                  2: queue_number();
                  default: queue_ident();
               endcase
            end
            3: queue_value(1'b1);
            default: queue_entry();
         endcase
      end
      put_byte(CHAR_NUL);
   endfunction

   // ------------------------------------------------------------------------
   // Phase control
   // ------------------------------------------------------------------------

   // Waits until every queued byte has been taken and every token has come
   // back, then waits out the settle stretch set by SETTLE_CYCLES.
   task automatic settle_idle();
      while (bytes_accepted != bytes_queued || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle, so no beat can slip in between.
   task automatic write_first_line(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      first_line_cfg    = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Text byte driver: takes bytes from the backlog, offers each one until it
   // is taken and scores it with the scanner on the beat. Idle gaps come in
   // random bursts while idling is enabled.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            tokenise_byte(req_text_byte);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
               send_gap   = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (text_backlog.size() != 0) begin
               req_valid     <= 1'b1;
               req_text_byte <= text_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Token receiver: stalls in random bursts, and once for a long stretch on
   // request so that the block's queue fills and the input side stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         stall_left        = LONG_HOLD - 1;
         rsp_stall        <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void compare_field(input string field,
                                         input logic [FIELD_BITS-1:0] want,
                                         input logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Token monitor: every accepted token beat is matched against the oldest
   // expected token.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : token_check
      token_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: token beat with none expected, expected nothing, got kind %0d",
                     $time, rsp_token_kind);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", FIELD_BITS'(want.kind), FIELD_BITS'(rsp_token_kind));
            compare_field("token_start", want.start, rsp_token_start);
            compare_field("token_length", want.length, rsp_token_length);
            compare_field("line_number", want.line, rsp_line_number);
            compare_field("run_last", FIELD_BITS'(want.run_last), FIELD_BITS'(rsp_run_last));
         end
      end
   end

   // A run that hangs anywhere ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("config_text_tokenizer_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      int mark;
      idle_enable = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed text: an identifier closed by a brace (two tokens from one
      // byte), a number closed by a brace, a string holding a newline, a
      // comma, a lone underscore and a high byte as unexpected bytes, then
      // the end arriving inside a comment, inside a string and straight
      // after an identifier closed by a newline.
      queue_text("a_1{9}=\"x\ny\",_");
      put_byte(8'hFF);
      queue_text("#c");
      put_byte(CHAR_NUL);
      queue_text("\"q");
      put_byte(CHAR_NUL);
      queue_text("z\n");
      put_byte(CHAR_NUL);
      settle_idle();
      write_first_line(1'b0);

      // Random phases. Every third one runs without idling; phase two also
      // brings the long receiver hold. Odd phases leave a text open across
      // the register write, which must not touch the line count in flight.
      phase = 0;
      mark  = bytes_queued;
      while (bytes_queued - mark < RANDOM_BYTES) begin
         int phase_mark;
         phase_mark  = bytes_queued;
         idle_enable = (phase % 3) != 2;
         if (phase == 2)
            long_hold_request = 1'b1;
         while (bytes_queued - phase_mark < PHASE_BYTES)
            queue_random_text();
         if (phase % 2)
            queue_text("x = 5\n");
         settle_idle();
         write_first_line(phase == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
         phase++;
      end

      // Tail with no idling on either side: random texts back to back.
      idle_enable = 1'b0;
      mark        = bytes_queued;
      while (bytes_queued - mark < TAIL_BYTES)
         queue_random_text();
      settle_idle();

      if (mismatches == 0)
         $display("config_text_tokenizer_unit regression: pass");
      else
         $display("config_text_tokenizer_unit regression: fail");
      $finish;
   end

endmodule
